/* rtl/cma_pkg.sv */
// Shared constants, types and state encoding for the centred moving average.
package cma_pkg;

  localparam int MAX_HALF_WIDTH = 31;
  localparam int VALUE_BITS     = 24;
  localparam int TIME_BITS      = 32;
  localparam int HW_BITS        = $clog2(MAX_HALF_WIDTH + 1);
  localparam int RING_DEPTH     = 2 * MAX_HALF_WIDTH + 2;
  localparam int LEN_BITS       = $clog2(RING_DEPTH);
  localparam int RING_AW        = LEN_BITS;
  localparam int SUM_BITS       = VALUE_BITS + LEN_BITS;
  localparam int DIV_CNT_BITS   = $clog2(SUM_BITS);
  localparam int IDX_BITS       = 7;
  localparam int INDEX_MAX      = 2 ** IDX_BITS - 1;
  localparam int ENTRY_BITS     = TIME_BITS + VALUE_BITS;

  typedef logic [TIME_BITS-1:0]         time_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [HW_BITS-1:0]           hw_t;
  typedef logic [LEN_BITS-1:0]          len_t;
  typedef logic [RING_AW-1:0]           addr_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [IDX_BITS-1:0]          idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_DLOAD = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_RREQ  = 7'b0100000,
    ST_RDAT  = 7'b1000000
  } state_t;

endpackage

/* rtl/cma_if.sv */
// Channel interfaces: sample input, result output and half width write.
interface cma_in_if;
  import cma_pkg::*;
  logic   valid;
  logic   ready;
  time_t  sample_time;
  value_t sample_value;
  logic   end_of_series;
  modport source (output valid, sample_time, sample_value, end_of_series, input ready);
  modport sink   (input valid, sample_time, sample_value, end_of_series, output ready);
endinterface

interface cma_out_if;
  import cma_pkg::*;
  logic   valid;
  logic   ready;
  time_t  out_time;
  value_t out_value;
  logic   averaged;
  logic   series_done;
  logic   too_short;
  modport source (output valid, out_time, out_value, averaged, series_done, too_short,
                  input ready);
  modport sink   (input valid, out_time, out_value, averaged, series_done, too_short,
                  output ready);
endinterface

interface cma_cfg_if;
  import cma_pkg::*;
  logic valid;
  logic ready;
  hw_t  half_width;
  modport source (output valid, half_width, input ready);
  modport sink   (input valid, half_width, output ready);
endinterface

/* rtl/centered_moving_average.sv */
// Centred moving average: top level with sample ring, window sum and result sequencing.
// A leading edge sample's raw result is staged on acceptance, sent when output is free.
// An averaged result follows a ring read of 2h+1 entries plus a serial divide by the
// window length; each flushed raw sample passes the read request and read data states.
// One sample is taken at a time; the next is taken once the previous results are queued.
// Reset clears control, index, head and sum and sets half width to 1; ring contents stay.
module centered_moving_average (
  input  logic       clk,
  input  logic       rst_n,
  cma_cfg_if.sink    cfg_ch,
  cma_in_if.sink     in_ch,
  cma_out_if.source  out_ch
);
  import cma_pkg::*;

  state_t state_r, state_nxt;
  hw_t    half_width_r;
  idx_t   idx_r, idx_nxt;
  addr_t  head_r, head_nxt;
  sum_t   window_sum_r, window_sum_nxt;
  len_t   sum_cnt_r, sum_cnt_nxt;
  hw_t    raw_cnt_r, raw_cnt_nxt;
  logic   last_r, last_nxt;
  logic   flush_short_r, flush_short_nxt;
  logic   acc_en_r, capt_r;
  logic   push_r, push_nxt;

  time_t  res_time_r, res_time_nxt;
  value_t res_value_r, res_value_nxt;
  logic   res_avg_r, res_avg_nxt;
  logic   res_done_r, res_done_nxt;
  logic   res_short_r, res_short_nxt;

  logic   out_valid_r, out_valid_nxt;
  time_t  out_time_r;
  value_t out_value_r;
  logic   out_avg_r, out_done_r, out_short_r;

  logic                in_acc, out_free, out_load;
  addr_t               raddr;
  logic [ENTRY_BITS-1:0] rdata;
  time_t               rd_time;
  value_t              rd_value;
  len_t                win_len;
  idx_t                hw_ext, hw_dbl;
  logic [SUM_BITS-1:0] dividend;
  sum_t                hw_sum;
  logic                div_done;
  logic [SUM_BITS-1:0] quotient;
  value_t              q_mag;

  assign in_ch.ready  = (state_r == ST_IDLE) && !push_r;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = push_r && out_free;

  assign win_len = {half_width_r, 1'b1};
  assign hw_ext  = IDX_BITS'(half_width_r);
  assign hw_dbl  = IDX_BITS'({half_width_r, 1'b0});
  assign hw_sum  = SUM_BITS'(half_width_r);

  assign raddr    = (state_r == ST_SUM) ? addr_t'(head_r - sum_cnt_r)
                                        : addr_t'(head_r - RING_AW'(raw_cnt_r));
  assign rd_time  = rdata[ENTRY_BITS-1:VALUE_BITS];
  assign rd_value = rdata[VALUE_BITS-1:0];

  cma_ram #(.WIDTH(ENTRY_BITS), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (head_r),
    .wdata ({in_ch.sample_time, in_ch.sample_value}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dividend = window_sum_r[SUM_BITS-1] ? SUM_BITS'(hw_sum - window_sum_r)
                                             : SUM_BITS'(window_sum_r + hw_sum);

  cma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DLOAD),
    .dividend (dividend),
    .divisor  (win_len),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_mag = quotient[VALUE_BITS-1:0];

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    head_nxt        = head_r;
    window_sum_nxt  = window_sum_r;
    sum_cnt_nxt     = sum_cnt_r;
    raw_cnt_nxt     = raw_cnt_r;
    last_nxt        = last_r;
    flush_short_nxt = flush_short_r;
    push_nxt        = push_r;
    res_time_nxt    = res_time_r;
    res_value_nxt   = res_value_r;
    res_avg_nxt     = res_avg_r;
    res_done_nxt    = res_done_r;
    res_short_nxt   = res_short_r;

    if (acc_en_r) begin
      window_sum_nxt = window_sum_r + SUM_BITS'(rd_value);
      if (capt_r) begin
        res_time_nxt = rd_time;
      end
    end

    if (out_load) begin
      push_nxt = 1'b0;
      if (raw_cnt_r != '0) begin
        state_nxt = ST_RREQ;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          head_nxt = head_r + 1'b1;
          last_nxt = in_ch.end_of_series;
          if (in_ch.end_of_series) begin
            idx_nxt = '0;
          end else if (idx_r != idx_t'(INDEX_MAX)) begin
            idx_nxt = idx_r + 1'b1;
          end
          if (idx_r < hw_ext) begin
            res_time_nxt  = in_ch.sample_time;
            res_value_nxt = in_ch.sample_value;
            res_avg_nxt   = 1'b0;
            res_done_nxt  = in_ch.end_of_series;
            res_short_nxt = in_ch.end_of_series;
            raw_cnt_nxt   = '0;
            push_nxt      = 1'b1;
          end else if (idx_r < hw_dbl) begin
            if (in_ch.end_of_series) begin
              raw_cnt_nxt     = HW_BITS'(idx_r - hw_ext + 1'b1);
              flush_short_nxt = 1'b1;
              state_nxt       = ST_RREQ;
            end
          end else begin
            window_sum_nxt = '0;
            sum_cnt_nxt    = win_len;
            state_nxt      = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (sum_cnt_r == len_t'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          sum_cnt_nxt = sum_cnt_r - 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_value_nxt   = window_sum_r[SUM_BITS-1] ? value_t'(-q_mag) : q_mag;
          res_avg_nxt     = 1'b1;
          res_done_nxt    = last_r && (half_width_r == '0);
          res_short_nxt   = 1'b0;
          raw_cnt_nxt     = last_r ? half_width_r : '0;
          flush_short_nxt = 1'b0;
          push_nxt        = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_RREQ: begin
        if (!push_r) begin
          state_nxt = ST_RDAT;
        end
      end
      ST_RDAT: begin
        res_time_nxt  = rd_time;
        res_value_nxt = rd_value;
        res_avg_nxt   = 1'b0;
        res_done_nxt  = (raw_cnt_r == hw_t'(1));
        res_short_nxt = flush_short_r;
        raw_cnt_nxt   = raw_cnt_r - 1'b1;
        push_nxt      = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      half_width_r  <= hw_t'(1);
      idx_r         <= '0;
      head_r        <= '0;
      window_sum_r  <= '0;
      sum_cnt_r     <= '0;
      raw_cnt_r     <= '0;
      last_r        <= 1'b0;
      flush_short_r <= 1'b0;
      acc_en_r      <= 1'b0;
      capt_r        <= 1'b0;
      push_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        half_width_r <= cfg_ch.half_width;
      end
      idx_r         <= idx_nxt;
      head_r        <= head_nxt;
      window_sum_r  <= window_sum_nxt;
      sum_cnt_r     <= sum_cnt_nxt;
      raw_cnt_r     <= raw_cnt_nxt;
      last_r        <= last_nxt;
      flush_short_r <= flush_short_nxt;
      acc_en_r      <= (state_r == ST_SUM);
      capt_r        <= (state_r == ST_SUM) && (sum_cnt_r == len_t'(half_width_r) + 1'b1);
      push_r        <= push_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_time_r  <= res_time_nxt;
    res_value_r <= res_value_nxt;
    res_avg_r   <= res_avg_nxt;
    res_done_r  <= res_done_nxt;
    res_short_r <= res_short_nxt;
    if (out_load) begin
      out_time_r  <= res_time_r;
      out_value_r <= res_value_r;
      out_avg_r   <= res_avg_r;
      out_done_r  <= res_done_r;
      out_short_r <= res_short_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_time    = out_time_r;
  assign out_ch.out_value   = out_value_r;
  assign out_ch.averaged    = out_avg_r;
  assign out_ch.series_done = out_done_r;
  assign out_ch.too_short   = out_short_r;

  a_raw_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> raw_cnt_r <= half_width_r)
    else $error("raw flush count exceeds half width");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider result outside divide state");

  a_sum_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> sum_cnt_r != '0)
    else $error("window read count ran out");

  a_done_ends_series: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res_done_r |=> state_r == ST_IDLE && idx_r == '0)
    else $error("series end result left work pending");

  a_load_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(push_r))
    else $error("result register loaded without a staged result");

endmodule

/* rtl/cma_ram.sv */
// Generic simple dual-port RAM with registered read.
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cma_div.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
module cma_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [cma_pkg::SUM_BITS-1:0] dividend,
  input  cma_pkg::len_t          divisor,
  output logic                   done,
  output logic [cma_pkg::SUM_BITS-1:0] quotient
);
  import cma_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0]     quo_r, quo_nxt;
  len_t                    rem_r, rem_nxt;
  len_t                    dsr_r, dsr_nxt;
  logic [LEN_BITS:0]       trial;
  logic                    fits;

  assign trial = {rem_r, quo_r[SUM_BITS-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_BITS'(SUM_BITS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_BITS-2:0], fits};
      rem_nxt = fits ? LEN_BITS'(trial - {1'b0, dsr_r}) : trial[LEN_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without running");

endmodule

/* verif/tb.sv */
// Self-checking bench for the centred moving average: stimulus, prediction and check.
`timescale 1ns / 100ps

module tb;
  import cma_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 40;
  localparam int IDLE_PERCENT  = 15;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 400;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct {
    time_t  stamp;
    value_t value;
    logic   averaged;
    logic   series_done;
    logic   too_short;
  } smooth_result_t;

  logic clk;
  logic rst_n;

  cma_cfg_if cfg_if ();
  cma_in_if  in_if ();
  cma_out_if out_if ();

  centered_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  hw_t    model_hw = hw_t'(1);
  value_t value_ring [RING_DEPTH];
  time_t  time_ring [RING_DEPTH];
  idx_t   model_index = '0;
  addr_t  model_head = '0;

  smooth_result_t smoothed_q [$];

  int  items_sent   = 0;
  int  series_count = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  hw_writes    = 0;
  int  hold_request = 0;
  int  cycle_count  = 0;
  bit  idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic addr_t slot_back(int back);
    return model_head - addr_t'(back);
  endfunction

  function automatic void push_raw(int back, logic done, logic flag);
    smooth_result_t r;
    addr_t s;
    s = slot_back(back);
    r.stamp       = time_ring[s];
    r.value       = value_ring[s];
    r.averaged    = 1'b0;
    r.series_done = done;
    r.too_short   = flag;
    smoothed_q.insert(smoothed_q.size(), r);
  endfunction

  function automatic void smooth_sample(time_t stamp, value_t value, logic eos);
    int h;
    int len;
    int i;
    longint sum;
    longint mag;
    longint q;
    smooth_result_t r;
    h   = int'(model_hw);
    len = 2 * h + 1;
    i   = int'(model_index);
    value_ring[model_head] = value;
    time_ring[model_head]  = stamp;
    model_head = model_head + 1'b1;
    if (i < h) begin
      push_raw(1, eos, eos);
    end else if (i < 2 * h) begin
      if (eos) begin
        for (int k = i - h + 1; k >= 1; k--) push_raw(k, k == 1, 1'b1);
      end
    end else begin
      sum = 0;
      for (int k = 1; k <= len; k++) sum += value_ring[slot_back(k)];
      mag = (sum < 0) ? -sum : sum;
      q   = (mag + h) / len;
      if (sum < 0) q = -q;
      r.stamp       = time_ring[slot_back(h + 1)];
      r.value       = q[VALUE_BITS-1:0];
      r.averaged    = 1'b1;
      r.series_done = eos && (h == 0);
      r.too_short   = 1'b0;
      smoothed_q.insert(smoothed_q.size(), r);
      if (eos) begin
        for (int k = h; k >= 1; k--) push_raw(k, k == 1, 1'b0);
      end
    end
    if (eos) model_index = '0;
    else if (i < INDEX_MAX) model_index = model_index + 1'b1;
  endfunction

  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return VALUE_MAX;
    if (pick < 20) return VALUE_MIN;
    return value_t'($urandom);
  endfunction

  task automatic send_sample(time_t stamp, value_t value, logic eos);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sample_time   <= stamp;
    in_if.sample_value  <= value;
    in_if.end_of_series <= eos;
    do @(posedge clk); while (!in_if.ready);
    smooth_sample(stamp, value, eos);
    items_sent++;
    if (eos) series_count++;
    @(negedge clk);
  endtask

  task automatic send_series(int count);
    for (int n = 0; n < count; n++) send_sample($urandom, random_value(), n == count - 1);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_half_width(hw_t hw);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.half_width <= hw;
    do @(posedge clk); while (!cfg_if.ready);
    model_hw = hw;
    hw_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_default_width();
    send_sample(32'h0000_0000, VALUE_MAX, 1'b0);
    send_sample(32'hFFFF_FFFF, VALUE_MIN, 1'b0);
    send_sample(32'h0000_0001, VALUE_MAX, 1'b0);
    send_sample(32'h0000_0002, -value_t'(1), 1'b1);
  endtask

  task automatic test_zero_width();
    write_half_width(hw_t'(0));
    send_sample(32'h0000_0000, VALUE_MAX, 1'b0);
    send_sample(32'hFFFF_FFFF, VALUE_MIN, 1'b0);
    send_sample(32'h0000_1234, -value_t'(1), 1'b1);
  endtask

  task automatic test_too_short();
    write_half_width(hw_t'(3));
    send_series(1);
    send_series(5);
  endtask

  task automatic test_width_change();
    write_half_width(hw_t'(2));
    for (int n = 0; n < 5; n++) send_sample($urandom, random_value(), 1'b0);
    write_half_width(hw_t'(4));
    for (int n = 0; n < 2; n++) send_sample($urandom, random_value(), 1'b0);
    write_half_width(hw_t'(1));
    send_sample($urandom, random_value(), 1'b0);
    write_half_width(hw_t'(5));
    send_sample($urandom, random_value(), 1'b1);
  endtask

  // run past the index saturation point with no idling on either side
  task automatic test_long_series();
    write_half_width(hw_t'(2));
    idle_on = 1'b0;
    send_series(130);
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    write_half_width(hw_t'(1));
    hold_request = HOLD_CYCLES;
    send_series(12);
  endtask

  task automatic test_random_series();
    int start;
    int h;
    int len;
    int split;
    int pick;
    bit first;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (first || pick < 8) h = MAX_HALF_WIDTH;
      else if (pick < 16) h = 0;
      else h = $urandom_range(1, 6);
      first = 1'b0;
      write_half_width(hw_t'(h));
      if (h == 0) len = $urandom_range(1, 10);
      else if ($urandom_range(99) < 80) len = $urandom_range(2 * h + 1, 2 * h + 10);
      else len = $urandom_range(1, 2 * h);
      split = (len > 1 && $urandom_range(99) < 15) ? $urandom_range(1, len - 1) : len;
      for (int n = 0; n < len; n++) begin
        if (n == split) write_half_width(hw_t'($urandom_range(0, 8)));
        send_sample($urandom, random_value(), n == len - 1);
      end
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    smooth_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (smoothed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: time %h value %0d avg %b done %b short %b",
                   out_if.out_time, out_if.out_value, out_if.averaged,
                   out_if.series_done, out_if.too_short);
      end else begin
        want = smoothed_q.pop_front();
        if (out_if.out_time !== want.stamp || out_if.out_value !== want.value ||
            out_if.averaged !== want.averaged || out_if.series_done !== want.series_done ||
            out_if.too_short !== want.too_short) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected time %h value %0d avg %b done %b short %b",
                     want.stamp, want.value, want.averaged, want.series_done,
                     want.too_short);
            $display("          got      time %h value %0d avg %b done %b short %b",
                     out_if.out_time, out_if.out_value, out_if.averaged,
                     out_if.series_done, out_if.too_short);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** centered_moving_average: FAILED **");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.sample_time   = '0;
    in_if.sample_value  = '0;
    in_if.end_of_series = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.half_width   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_width();
    test_zero_width();
    test_too_short();
    test_width_change();
    test_long_series();
    test_back_pressure();
    test_random_series();

    wait_idle();
    $display("covered %0d samples in %0d series, %0d results checked, %0d mismatches",
             items_sent, series_count, results_seen, mismatches);
    $display("half width written %0d times: 0, 31, mid-series changes, long receiver hold",
             hw_writes);
    if (mismatches == 0) begin
      $display("** centered_moving_average: PASSED **");
    end else begin
      $display("** centered_moving_average: FAILED **");
    end
    $finish;
  end

endmodule
